/* hdl/line_follow_pd_steering_assert.svh */
// Assertion helpers for the line follower steering block.
// Both macros sample on i_clk and are disabled while i_rst_n is low.
`ifndef LINE_FOLLOW_PD_STEERING_ASSERT_SVH
`define LINE_FOLLOW_PD_STEERING_ASSERT_SVH

`ifndef SYNTHESIS
// Property holds at every clock edge out of reset.
`define LFPD_ASSERT(name, prop) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("lfpd assertion failed");
// Antecedent implies consequent in the same cycle.
`define LFPD_IMPLY(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lfpd implication failed");
`else
`define LFPD_ASSERT(name, prop)
`define LFPD_IMPLY(name, ante, cons)
`endif

`endif

/* hdl/lfpd_pkg.sv */
`timescale 1ns / 1ps

package lfpd_pkg;

    // Default sensor sample width
    localparam int SAMPLE_BITS_DEF = 10;

    // Speed reduction on a cross line
    localparam logic [7:0] CROSS_SLOWDOWN = 8'd25;

    // Register reset values
    localparam int         SET_POINT_RESET = 0;
    localparam logic [7:0] TOP_SPEED_RESET = 8'd255;
    localparam int         OFF_LINE_RESET  = 103;
    localparam int         CROSS_RESET     = 972;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_SET_POINT = 2'd0,
        CFG_TOP_SPEED = 2'd1,
        CFG_OFF_LINE  = 2'd2,
        CFG_CROSS     = 2'd3
    } t_cfg_idx;

    // Zone codes
    typedef enum logic [1:0] {
        ZONE_OFF   = 2'd0,
        ZONE_CROSS = 2'd1,
        ZONE_TRACK = 2'd2
    } t_zone;

    // One steering result
    typedef struct packed {
        logic       set_forward;
        t_zone      zone;
        logic [7:0] right_speed;
        logic [7:0] left_speed;
    } t_result;

endpackage

/* hdl/line_follow_pd_steering.sv */
`timescale 1ns / 1ps
`include "line_follow_pd_steering_assert.svh"

// Line follower PD steering. Each sensor beat on the slave stream yields one beat of
// wheel speeds on the master stream. One beat is accepted every cycle unless the master
// stream stalls; a sample beat is captured in the input register and its result beat
// in the result register, and the whole computation sits between those two registers
// so that the stored last error is up to date for the very next sample. Samples below
// off_line_level stop both wheels, samples above cross_level run both at top_speed - 25
// floored at zero, and in between the PD term 1.5*error + 5*derivative (truncated,
// clamped to +-top_speed) slows the inner wheel. Configuration must be written through
// a simple write port only while the block is idle; the block does not enforce this.
// Indexes are 0 set_point, 1 top_speed, 2 off_line_level, 3 cross_level.
module line_follow_pd_steering #(
    parameter int SAMPLE_BITS = lfpd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Sensor stream
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] i_s_tdata,   // [S-1:0] sample, rest zero
    // Steering stream
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [23:0]                o_m_tdata,   // [7:0] left_speed, [15:8] right_speed,
                                                    // [16] set_forward, rest zero
    output logic [1:0]                 o_m_tuser,   // [1:0] zone
    // Configuration
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_addr,
    input  logic [SAMPLE_BITS-1:0]     i_cfg_wdata
);

    logic [SAMPLE_BITS-1:0]      set_point;
    logic [7:0]                  top_speed;
    logic [SAMPLE_BITS-1:0]      off_line;
    logic [SAMPLE_BITS-1:0]      cross_lvl;
    logic                        advance;
    logic                        r_in_valid;
    logic [SAMPLE_BITS-1:0]      r_sample;
    logic                        r_out_valid;
    lfpd_pkg::t_result           r_result;
    lfpd_pkg::t_result           core_result;
    logic signed [SAMPLE_BITS:0] r_last_error;
    logic signed [SAMPLE_BITS:0] core_error;
    logic                        core_error_we;

    lfpd_cfg_regs #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_set_point (set_point),
        .o_top_speed (top_speed),
        .o_off_line  (off_line),
        .o_cross     (cross_lvl)
    );

    lfpd_core #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .i_sample     (r_sample),
        .i_last_error (r_last_error),
        .i_set_point  (set_point),
        .i_top_speed  (top_speed),
        .i_off_line   (off_line),
        .i_cross      (cross_lvl),
        .o_result     (core_result),
        .o_error      (core_error),
        .o_error_we   (core_error_we)
    );

    // Pipeline flow control
    assign advance    = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_sample <= i_s_tdata[SAMPLE_BITS-1:0];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_result <= core_result;
        end
    end

    // Last error, updated as a tracking beat moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_error <= '0;
        end else if (advance && r_in_valid && core_error_we) begin
            r_last_error <= core_error;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_result.set_forward, r_result.right_speed,
                         r_result.left_speed};
    assign o_m_tuser  = r_result.zone;

    // Checks
    `LFPD_IMPLY(a_off_line_stopped, o_m_tvalid && o_m_tuser == lfpd_pkg::ZONE_OFF,
                o_m_tdata[16:0] == 17'd0)
    `LFPD_IMPLY(a_track_outer_full, o_m_tvalid && o_m_tuser == lfpd_pkg::ZONE_TRACK,
                o_m_tdata[16] && (o_m_tdata[7:0] == top_speed || o_m_tdata[15:8] == top_speed))
    `LFPD_IMPLY(a_error_update_src, r_last_error != $past(r_last_error),
                $past(advance && r_in_valid && core_error_we))
    `LFPD_ASSERT(a_ready_when_empty, !r_out_valid |-> o_s_tready)

endmodule

/* hdl/lfpd_cfg_regs.sv */
`timescale 1ns / 1ps

module lfpd_cfg_regs #(
    parameter int SAMPLE_BITS = lfpd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_addr,
    input  logic [SAMPLE_BITS-1:0] i_cfg_wdata,
    output logic [SAMPLE_BITS-1:0] o_set_point,
    output logic [7:0]             o_top_speed,
    output logic [SAMPLE_BITS-1:0] o_off_line,
    output logic [SAMPLE_BITS-1:0] o_cross
);

    logic [SAMPLE_BITS-1:0] r_set_point;
    logic [7:0]             r_top_speed;
    logic [SAMPLE_BITS-1:0] r_off_line;
    logic [SAMPLE_BITS-1:0] r_cross;

    // Register file, written by index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_point <= SAMPLE_BITS'(lfpd_pkg::SET_POINT_RESET);
            r_top_speed <= lfpd_pkg::TOP_SPEED_RESET;
            r_off_line  <= SAMPLE_BITS'(lfpd_pkg::OFF_LINE_RESET);
            r_cross     <= SAMPLE_BITS'(lfpd_pkg::CROSS_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                lfpd_pkg::CFG_SET_POINT: r_set_point <= i_cfg_wdata;
                lfpd_pkg::CFG_TOP_SPEED: r_top_speed <= i_cfg_wdata[7:0];
                lfpd_pkg::CFG_OFF_LINE:  r_off_line  <= i_cfg_wdata;
                lfpd_pkg::CFG_CROSS:     r_cross     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_set_point = r_set_point;
    assign o_top_speed = r_top_speed;
    assign o_off_line  = r_off_line;
    assign o_cross     = r_cross;

endmodule

/* hdl/lfpd_core.sv */
`timescale 1ns / 1ps

module lfpd_core #(
    parameter int SAMPLE_BITS = lfpd_pkg::SAMPLE_BITS_DEF
) (
    input  logic [SAMPLE_BITS-1:0]        i_sample,
    input  logic signed [SAMPLE_BITS:0]   i_last_error,
    input  logic [SAMPLE_BITS-1:0]        i_set_point,
    input  logic [7:0]                    i_top_speed,
    input  logic [SAMPLE_BITS-1:0]        i_off_line,
    input  logic [SAMPLE_BITS-1:0]        i_cross,
    output lfpd_pkg::t_result             o_result,
    output logic signed [SAMPLE_BITS:0]   o_error,
    output logic                          o_error_we
);

    // Drive arithmetic width: 10*derivative needs S+6 bits, sum one more
    localparam int DW = SAMPLE_BITS + 7;

    logic signed [SAMPLE_BITS:0]   err;
    logic signed [SAMPLE_BITS+1:0] der;
    logic signed [DW-1:0]          err_x;
    logic signed [DW-1:0]          der_x;
    logic signed [DW-1:0]          sum;
    logic signed [DW-1:0]          sum_adj;
    logic signed [DW-1:0]          drive;
    logic signed [DW-1:0]          drive_sat;
    logic signed [DW-1:0]          top_x;
    logic signed [DW-1:0]          left_x;
    logic signed [DW-1:0]          right_x;
    logic [7:0]                    cross_speed;
    logic                          off_line;
    logic                          cross_line;

    // Error and derivative
    assign err   = $signed({1'b0, i_sample}) - $signed({1'b0, i_set_point});
    assign der   = (SAMPLE_BITS+2)'(err) - (SAMPLE_BITS+2)'(i_last_error);
    assign err_x = DW'(err);
    assign der_x = DW'(der);

    // 3e + 10d, halved toward zero
    assign sum     = (err_x <<< 1) + err_x + (der_x <<< 3) + (der_x <<< 1);
    assign sum_adj = sum + $signed({{(DW-1){1'b0}}, sum[DW-1]});
    assign drive   = sum_adj >>> 1;

    // Clamp to +-top speed
    assign top_x = $signed({{(DW-8){1'b0}}, i_top_speed});
    always_comb begin
        if (drive > top_x) begin
            drive_sat = top_x;
        end else if (drive < -top_x) begin
            drive_sat = -top_x;
        end else begin
            drive_sat = drive;
        end
    end

    // Slow the inner wheel
    always_comb begin
        if (drive_sat < 0) begin
            left_x  = top_x + drive_sat;
            right_x = top_x;
        end else begin
            left_x  = top_x;
            right_x = top_x - drive_sat;
        end
    end

    // Cross line speed, floored at zero
    assign cross_speed = (i_top_speed < lfpd_pkg::CROSS_SLOWDOWN) ? 8'd0
                       : i_top_speed - lfpd_pkg::CROSS_SLOWDOWN;

    // Zone decode: off line wins over cross line
    assign off_line   = i_sample < i_off_line;
    assign cross_line = i_sample > i_cross;

    always_comb begin
        if (off_line) begin
            o_result.left_speed  = 8'd0;
            o_result.right_speed = 8'd0;
            o_result.zone        = lfpd_pkg::ZONE_OFF;
            o_result.set_forward = 1'b0;
        end else if (cross_line) begin
            o_result.left_speed  = cross_speed;
            o_result.right_speed = cross_speed;
            o_result.zone        = lfpd_pkg::ZONE_CROSS;
            o_result.set_forward = 1'b0;
        end else begin
            o_result.left_speed  = left_x[7:0];
            o_result.right_speed = right_x[7:0];
            o_result.zone        = lfpd_pkg::ZONE_TRACK;
            o_result.set_forward = 1'b1;
        end
    end

    // Error is kept only while tracking
    assign o_error    = err;
    assign o_error_we = !off_line && !cross_line;

endmodule

/* dv/line_follow_pd_steering_test.sv */
`timescale 1ns / 1ps

module line_follow_pd_steering_test;
    import lfpd_pkg::*;

    localparam int SB   = SAMPLE_BITS_DEF;
    localparam int IN_W = ((SB + 7) / 8) * 8;
    localparam int MAX_SAMPLE = (1 << SB) - 1;

    logic            i_clk       = 1'b0;
    logic            i_rst_n     = 1'b0;
    logic            i_s_tvalid  = 1'b0;
    logic            o_s_tready;
    logic [IN_W-1:0] i_s_tdata   = '0;   // [SB-1:0] sample, rest zero
    logic            o_m_tvalid;
    logic            i_m_tready  = 1'b0;
    logic [23:0]     o_m_tdata;          // [7:0] left, [15:8] right, [16] set_forward
    logic [1:0]      o_m_tuser;          // [1:0] zone
    logic            i_cfg_we    = 1'b0;
    logic [1:0]      i_cfg_addr  = '0;
    logic [SB-1:0]   i_cfg_wdata = '0;

    line_follow_pd_steering #(.SAMPLE_BITS(SB)) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shared between stimulus, driver and scoreboard
    logic [SB-1:0] sample_backlog[$];
    t_result       speeds_due[$];
    bit            steady_tail = 1'b0;
    int            errors      = 0;
    int            settings_run = 0;
    int            zone_hits[3] = '{0, 0, 0};

    // Steering model: registers and stored error
    logic [SB-1:0]        sp_m, off_m, cross_m;
    logic [7:0]           top_m;
    logic signed [SB+1:0] err_hist;

    function automatic t_result predict_speeds(input logic [SB-1:0] smp);
        t_result r;
        int top, err, der, drv;
        r   = '0;
        top = int'(top_m);
        if (smp < off_m) begin
            r.zone = ZONE_OFF;
        end else if (smp > cross_m) begin
            // cross line slowdown floors at zero
            drv = top - int'(CROSS_SLOWDOWN);
            if (drv < 0) drv = 0;
            r.left_speed  = drv[7:0];
            r.right_speed = drv[7:0];
            r.zone        = ZONE_CROSS;
        end else begin
            err = int'(smp) - int'(sp_m);
            der = err - int'(err_hist);
            drv = (3 * err + 10 * der) / 2;   // truncates toward zero
            err_hist = err[SB+1:0];
            if (drv > top)  drv = top;
            if (drv < -top) drv = -top;
            if (drv < 0) begin
                r.left_speed  = 8'(top + drv);
                r.right_speed = top_m;
            end else begin
                r.left_speed  = top_m;
                r.right_speed = 8'(top - drv);
            end
            r.zone        = ZONE_TRACK;
            r.set_forward = 1'b1;
        end
        return r;
    endfunction

    // Sensor beat driver with random idle bursts
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            send_gap = 0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (i_s_tvalid) sample_backlog.delete(0);
            if (send_gap > 0) begin
                send_gap--;
                i_s_tvalid <= 1'b0;
            end else if (sample_backlog.size() != 0 && !steady_tail &&
                         $urandom_range(7, 0) == 0) begin
                send_gap = $urandom_range(6, 0);
                i_s_tvalid <= 1'b0;
            end else if (sample_backlog.size() != 0) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= IN_W'(sample_backlog[0]);
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Scoreboard: tracks register writes, predicts on accepted samples,
    // checks result beats and drives ready with random stalls
    int stall_left = 0;
    always @(posedge i_clk) begin : scoreboard
        t_result got, want;
        if (!i_rst_n) begin
            sp_m       = SB'(SET_POINT_RESET);
            top_m      = TOP_SPEED_RESET;
            off_m      = SB'(OFF_LINE_RESET);
            cross_m    = SB'(CROSS_RESET);
            err_hist   = '0;
            stall_left = 0;
            i_m_tready <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_SET_POINT: sp_m    = i_cfg_wdata;
                    CFG_TOP_SPEED: top_m   = i_cfg_wdata[7:0];
                    CFG_OFF_LINE:  off_m   = i_cfg_wdata;
                    CFG_CROSS:     cross_m = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_s_tvalid && o_s_tready)
                speeds_due.push_back(predict_speeds(i_s_tdata[SB-1:0]));

            if (o_m_tvalid && i_m_tready) begin
                got = {o_m_tdata[16], t_zone'(o_m_tuser), o_m_tdata[15:8], o_m_tdata[7:0]};
                if (speeds_due.size() == 0) begin
                    errors++;
                    $display({"%0t: unexpected result beat, expected none,",
                              " got L=%0d R=%0d zone=%0d fwd=%0d"},
                             $time, got.left_speed, got.right_speed, got.zone,
                             got.set_forward);
                end else begin
                    want = speeds_due.pop_front();
                    if (got.zone <= ZONE_TRACK) zone_hits[got.zone]++;
                    if (got !== want || o_m_tdata[23:17] !== 7'd0) begin
                        errors++;
                        $display({"%0t: mismatch, expected L=%0d R=%0d zone=%0d fwd=%0d,",
                                  " got L=%0d R=%0d zone=%0d fwd=%0d pad=%h"},
                                 $time, want.left_speed, want.right_speed, want.zone,
                                 want.set_forward, got.left_speed, got.right_speed,
                                 got.zone, got.set_forward, o_m_tdata[23:17]);
                    end
                end
            end

            if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else if (!steady_tail && $urandom_range(7, 0) == 0) begin
                stall_left = $urandom_range(6, 0);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [SB-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Checked at the falling edge so all rising-edge updates have settled
    task automatic wait_idle;
        do @(negedge i_clk);
        while (sample_backlog.size() != 0 || speeds_due.size() != 0);
        repeat (4) @(negedge i_clk);
        settings_run++;
    endtask

    task automatic send(input int s);
        sample_backlog.push_back(SB'(s));
    endtask

    // Mostly samples around the set point so the derivative term gets exercised
    task automatic send_tracking(input int n, input int aim);
        int s;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(3, 0))
                0: s = aim + $urandom_range(6, 0) - 3;
                1: s = aim + $urandom_range(60, 0) - 30;
                2: s = aim + $urandom_range(400, 0) - 200;
                default: s = $urandom_range(MAX_SAMPLE, 0);
            endcase
            if (s < 0) s = 0;
            if (s > MAX_SAMPLE) s = MAX_SAMPLE;
            send(s);
        end
    endtask

    initial begin : stimulus
        int aim, top_raw, off_v, cross_v;
        int reset_pts[10];
        int swing_pts[9];

        reset_pts = '{0, 102, 103, 104, 500, 971, 972, 973, 1023, 103};
        swing_pts = '{512, 513, 511, 0, 1023, 0, 512, 700, 300};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset register values: zone edges around both thresholds
        foreach (reset_pts[k])
            send(reset_pts[k]);
        wait_idle();

        // Centered set point, thresholds open: full-scale swings saturate drive
        write_reg(CFG_SET_POINT, SB'(512));
        write_reg(CFG_TOP_SPEED, SB'(255));
        write_reg(CFG_OFF_LINE,  SB'(0));
        write_reg(CFG_CROSS,     SB'(MAX_SAMPLE));
        foreach (swing_pts[k])
            send(swing_pts[k]);
        wait_idle();

        // Overlapping thresholds (off line wins), top speed below the cross slowdown,
        // upper write bits on top_speed dropped
        write_reg(CFG_OFF_LINE,  SB'(600));
        write_reg(CFG_CROSS,     SB'(400));
        write_reg(CFG_TOP_SPEED, SB'('h30A));
        send(500); send(700); send(300);
        wait_idle();
        write_reg(CFG_TOP_SPEED, SB'(0));
        write_reg(CFG_OFF_LINE,  SB'(100));
        write_reg(CFG_CROSS,     SB'(900));
        send(950); send(500); send(520);
        wait_idle();
        write_reg(CFG_TOP_SPEED, SB'(25));
        send(950); send(480);
        wait_idle();

        // Random register settings, each followed by a run of samples
        for (int p = 0; p < 8; p++) begin
            aim = $urandom_range(MAX_SAMPLE, 0);
            if ($urandom_range(3, 0) == 0) aim = $urandom_range(1, 0) ? MAX_SAMPLE : 0;
            top_raw = $urandom_range(MAX_SAMPLE, 0);
            case ($urandom_range(7, 0))
                0, 1: top_raw = 255;
                2:    top_raw = 25;
                default: ;
            endcase
            off_v   = $urandom_range(300, 0);
            cross_v = $urandom_range(MAX_SAMPLE, 700);
            if ($urandom_range(7, 0) == 0) begin
                off_v   = $urandom_range(MAX_SAMPLE, 0);
                cross_v = $urandom_range(MAX_SAMPLE, 0);
            end
            if (p == 7) begin
                // closing stretch runs at full rate on both sides
                steady_tail = 1'b1;
                off_v   = OFF_LINE_RESET;
                cross_v = CROSS_RESET;
            end
            write_reg(CFG_SET_POINT, SB'(aim));
            write_reg(CFG_TOP_SPEED, SB'(top_raw));
            write_reg(CFG_OFF_LINE,  SB'(off_v));
            write_reg(CFG_CROSS,     SB'(cross_v));
            send_tracking(p == 7 ? 300 : 240, aim);
            wait_idle();
        end

        $display({"Covered %0d register settings; results: %0d off line,",
                  " %0d cross line, %0d tracking."},
                 settings_run, zone_hits[ZONE_OFF], zone_hits[ZONE_CROSS],
                 zone_hits[ZONE_TRACK]);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", errors);
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin
        #2000000;
        $display("Timeout with %0d samples pending and %0d results due",
                 sample_backlog.size(), speeds_due.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
